[rtl/pidc_pkg.sv]
// Shared types and constants for the sampled PID controller.
// Used by the channel interfaces, the sample datapath and the top level.
`default_nettype none

package pidc_pkg;

  localparam int DATA_W    = 16;
  localparam int TIME_W    = 32;
  localparam int ACC_W     = 25;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [DATA_W-1:0] PERIOD_RESET = 16'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_AUTO   = 2'd1,
    CMD_MANUAL = 2'd2
  } pidc_cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_OUT_MIN    = 3'd3,
    REG_OUT_MAX    = 3'd4,
    REG_PERIOD     = 3'd5
  } pidc_reg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] prop_gain;
    logic signed [DATA_W-1:0] integ_gain;
    logic signed [DATA_W-1:0] deriv_gain;
    logic signed [DATA_W-1:0] out_min;
    logic signed [DATA_W-1:0] out_max;
    logic        [DATA_W-1:0] sample_period_ms;
  } pidc_cfg_t;

  typedef struct packed {
    logic                     loop_enabled;
    logic signed [ACC_W-1:0]  integral_acc;
    logic signed [DATA_W-1:0] prev_measurement;
    logic signed [DATA_W-1:0] held_output;
    logic        [TIME_W-1:0] last_sample_time;
  } pidc_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] setpoint;
    logic signed [DATA_W-1:0] measurement;
    logic        [TIME_W-1:0] time_ms;
  } pidc_item_t;

endpackage

`default_nettype wire

[rtl/pidc_if.sv]
// Valid/ready channel interfaces for the sampled PID controller.
// Depends on pidc_pkg for field widths.
`default_nettype none

interface pidc_in_if;
  logic                               valid;
  logic                               ready;
  logic [pidc_pkg::CMD_W-1:0]         cmd;
  logic signed [pidc_pkg::DATA_W-1:0] setpoint;
  logic signed [pidc_pkg::DATA_W-1:0] measurement;
  logic [pidc_pkg::TIME_W-1:0]        time_ms;

  modport source (output valid, cmd, setpoint, measurement, time_ms, input ready);
  modport sink   (input valid, cmd, setpoint, measurement, time_ms, output ready);
endinterface

interface pidc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pidc_pkg::DATA_W-1:0] control_output;
  logic                               updated;

  modport source (output valid, control_output, updated, input ready);
  modport sink   (input valid, control_output, updated, output ready);
endinterface

`default_nettype wire

[rtl/pid_controller_sampled_top.sv]
// Top level of the sampled PID controller: channel registers, controller state,
// configuration registers. Depends on pidc_pkg, pidc_if and pidc_step.
//
//   port         dir   transaction
//   sample_in    sink  cmd, setpoint, measurement, time_ms
//   result_out   src   control_output, updated (one per input transaction)
//   cfg_*        in    write enable, register index, 16-bit data
//
// One transaction per cycle sustained while the result is not stalled; accepted
// transactions pass the input register, the combinational datapath (three 16x17
// multiplies, adds and clamps) and the result register. A stalled result holds
// the datapath; the input register still takes one more transaction. Synchronous
// reset clears state, handshakes and gains/limits; the period resets to 1000 ms.
`default_nettype none

module pid_controller_sampled_top (
  input  logic                                 clk,
  input  logic                                 rst,
  pidc_in_if.sink                              sample_in,
  pidc_out_if.source                           result_out,
  input  logic                                 cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pidc_pkg::DATA_W-1:0]          cfg_data
);
  import pidc_pkg::*;

  pidc_cfg_t   cfg;
  pidc_state_t st;
  pidc_state_t st_next;
  pidc_item_t  item;
  logic        item_valid;
  logic        step_updated;
  logic        res_valid;
  logic signed [DATA_W-1:0] res_output;
  logic        res_updated;
  logic        advance;
  logic        proc;

  assign advance         = !res_valid || result_out.ready;
  assign proc            = item_valid && advance;
  assign sample_in.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (sample_in.ready) begin
      item_valid <= sample_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_in.valid && sample_in.ready) begin
      item.cmd         <= sample_in.cmd;
      item.setpoint    <= sample_in.setpoint;
      item.measurement <= sample_in.measurement;
      item.time_ms     <= sample_in.time_ms;
    end
  end

  pidc_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .updated (step_updated)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (proc) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res_output  <= st_next.held_output;
      res_updated <= step_updated;
    end
  end

  assign result_out.valid          = res_valid;
  assign result_out.control_output = res_output;
  assign result_out.updated        = res_updated;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain        <= '0;
      cfg.integ_gain       <= '0;
      cfg.deriv_gain       <= '0;
      cfg.out_min          <= '0;
      cfg.out_max          <= '0;
      cfg.sample_period_ms <= PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (pidc_reg_t'(cfg_index))
        REG_PROP_GAIN:  cfg.prop_gain        <= cfg_data;
        REG_INTEG_GAIN: cfg.integ_gain       <= cfg_data;
        REG_DERIV_GAIN: cfg.deriv_gain       <= cfg_data;
        REG_OUT_MIN:    cfg.out_min          <= cfg_data;
        REG_OUT_MAX:    cfg.out_max          <= cfg_data;
        REG_PERIOD:     cfg.sample_period_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A computed result can only come from automatic mode.
  a_updated_auto: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.updated |-> st.loop_enabled)
    else $error("updated result while loop disabled");

  // Mode commands never produce a new sample.
  a_mode_no_update: assert property (@(posedge clk) disable iff (rst)
    proc && (pidc_cmd_t'(item.cmd) != CMD_SAMPLE) |-> !step_updated)
    else $error("mode command flagged as sample");

  // With sane limits a new output stays inside them.
  a_out_in_range: assert property (@(posedge clk) disable iff (rst)
    proc && step_updated && (cfg.out_min <= cfg.out_max) |=>
      (st.held_output >= $past(cfg.out_min)) && (st.held_output <= $past(cfg.out_max)))
    else $error("held output outside limits");

  // Anti-windup keeps the integral inside the scaled limits.
  a_integ_in_range: assert property (@(posedge clk) disable iff (rst)
    proc && step_updated && (cfg.out_min <= cfg.out_max) |=>
      (st.integral_acc >= ACC_W'($past(cfg.out_min) * 256)) &&
      (st.integral_acc <= ACC_W'($past(cfg.out_max) * 256)))
    else $error("integral outside limits");

  // An item waiting behind a stalled result stays put.
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid && $stable(item))
    else $error("input register lost a waiting transaction");

endmodule

`default_nettype wire

[rtl/pidc_step.sv]
// Combinational next-state logic for one controller transaction.
// Depends on pidc_pkg for the config, state and item structs.
`default_nettype none

module pidc_step (
  input  pidc_pkg::pidc_cfg_t   cfg,
  input  pidc_pkg::pidc_state_t st,
  input  pidc_pkg::pidc_item_t  item,
  output pidc_pkg::pidc_state_t st_next,
  output logic                  updated
);
  import pidc_pkg::*;

  logic signed [DATA_W:0]     err;
  logic signed [DATA_W:0]     dmeas;
  logic signed [2*DATA_W:0]   p_term;
  logic signed [2*DATA_W:0]   i_term;
  logic signed [2*DATA_W:0]   d_term;
  logic signed [2*DATA_W+1:0] acc_sum;
  logic signed [2*DATA_W+1:0] acc_lo;
  logic signed [2*DATA_W+1:0] acc_hi;
  logic signed [ACC_W-1:0]    acc_clamped;
  logic signed [2*DATA_W+2:0] total;
  logic signed [2*DATA_W-6:0] scaled;
  logic signed [2*DATA_W-6:0] out_lo;
  logic signed [2*DATA_W-6:0] out_hi;
  logic signed [DATA_W-1:0]   out_clamped;
  logic signed [ACC_W-1:0]    bump_val;
  logic signed [ACC_W-1:0]    bump_lo;
  logic signed [ACC_W-1:0]    bump_hi;
  logic signed [ACC_W-1:0]    bump_clamped;
  logic [TIME_W-1:0]          elapsed;
  logic                       due;
  logic                       want_auto;

  // Sample path: error, integral update with anti-windup, then the clamped output sum.
  always_comb begin
    err    = {item.setpoint[DATA_W-1], item.setpoint}
           - {item.measurement[DATA_W-1], item.measurement};
    dmeas  = {item.measurement[DATA_W-1], item.measurement}
           - {st.prev_measurement[DATA_W-1], st.prev_measurement};
    p_term = cfg.prop_gain * err;
    i_term = cfg.integ_gain * err;
    d_term = cfg.deriv_gain * dmeas;

    acc_sum = {{(2*DATA_W+2-ACC_W){st.integral_acc[ACC_W-1]}}, st.integral_acc}
            + {i_term[2*DATA_W], i_term};
    acc_lo  = {{(DATA_W+2-8){cfg.out_min[DATA_W-1]}}, cfg.out_min, 8'd0};
    acc_hi  = {{(DATA_W+2-8){cfg.out_max[DATA_W-1]}}, cfg.out_max, 8'd0};
    if (acc_sum > acc_hi) begin
      acc_clamped = acc_hi[ACC_W-1:0];
    end else if (acc_sum < acc_lo) begin
      acc_clamped = acc_lo[ACC_W-1:0];
    end else begin
      acc_clamped = acc_sum[ACC_W-1:0];
    end

    total = {{2{p_term[2*DATA_W]}}, p_term}
          + {{(2*DATA_W+3-ACC_W){acc_clamped[ACC_W-1]}}, acc_clamped}
          - {{2{d_term[2*DATA_W]}}, d_term};
    // Arithmetic shift right by 8 is a floor division by 256.
    scaled = total[2*DATA_W+2:8];
    out_lo = {{(DATA_W-5){cfg.out_min[DATA_W-1]}}, cfg.out_min};
    out_hi = {{(DATA_W-5){cfg.out_max[DATA_W-1]}}, cfg.out_max};
    if (scaled > out_hi) begin
      out_clamped = cfg.out_max;
    end else if (scaled < out_lo) begin
      out_clamped = cfg.out_min;
    end else begin
      out_clamped = scaled[DATA_W-1:0];
    end
  end

  // Bumpless transfer: the integral restarts from the held output.
  always_comb begin
    bump_val = {st.held_output[DATA_W-1], st.held_output, 8'd0};
    bump_lo  = acc_lo[ACC_W-1:0];
    bump_hi  = acc_hi[ACC_W-1:0];
    if (bump_val > bump_hi) begin
      bump_clamped = bump_hi;
    end else if (bump_val < bump_lo) begin
      bump_clamped = bump_lo;
    end else begin
      bump_clamped = bump_val;
    end
  end

  assign elapsed = item.time_ms - st.last_sample_time;
  assign due     = st.loop_enabled && (elapsed >= {{(TIME_W-DATA_W){1'b0}}, cfg.sample_period_ms});

  always_comb begin
    st_next   = st;
    updated   = 1'b0;
    want_auto = 1'b0;
    case (pidc_cmd_t'(item.cmd))
      CMD_SAMPLE: begin
        if (due) begin
          st_next.integral_acc     = acc_clamped;
          st_next.held_output      = out_clamped;
          st_next.prev_measurement = item.measurement;
          st_next.last_sample_time = item.time_ms;
          updated                  = 1'b1;
        end
      end
      CMD_AUTO: begin
        want_auto = 1'b1;
      end
      default: begin
        // Manual, and the unused fourth code, both switch to manual.
        want_auto = 1'b0;
      end
    endcase
    if (pidc_cmd_t'(item.cmd) != CMD_SAMPLE) begin
      if (want_auto != st.loop_enabled) begin
        st_next.prev_measurement = item.measurement;
        st_next.integral_acc     = bump_clamped;
      end
      st_next.loop_enabled = want_auto;
    end
  end

endmodule

`default_nettype wire
